### src/brs_pkg.sv
// Package for the bisection root search block.
// Holds the register, state, item and result types and the status codes.
// No dependencies; every other file of the block uses it by scoped names.
package brs_pkg;

  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [CfgIndexWidth-1:0] CFG_TOLERANCE       = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_ITERATION_LIMIT = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_NEAR_ZERO_LIMIT = 2'd2;

  localparam logic [30:0] TOLERANCE_RESET       = 31'd7;
  localparam logic [15:0] ITERATION_LIMIT_RESET = 16'd1000;
  localparam logic [30:0] NEAR_ZERO_LIMIT_RESET = 31'd1;

  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_BAD_RANGE  = 3'd1;
  localparam logic [2:0] STATUS_LIMIT_HIT  = 3'd2;
  localparam logic [2:0] STATUS_NEAR_ZERO  = 3'd3;
  localparam logic [2:0] STATUS_UNEXPECTED = 3'd4;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_REPLY = 1'b1;

  typedef struct packed {
    logic [30:0] tolerance;
    logic [15:0] iteration_limit;
    logic [30:0] near_zero_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] left_end;
    logic signed [31:0] right_end;
    logic               left_sign_negative;
    logic signed [31:0] pending_midpoint;
    logic [15:0]        iteration_count;
    logic               searching;
  } state_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic signed [31:0] low_value;
    logic signed [31:0] high_value;
    logic signed [31:0] function_value;
  } item_t;

  typedef struct packed {
    logic               finished;
    logic signed [31:0] point;
    logic               root_valid;
    logic [2:0]         status_code;
    logic [15:0]        iterations_done;
  } result_t;

endpackage

### src/brs_ifs.sv
// Channel interfaces of the bisection root search block.
// Input item, result item and configuration write channels.
// Depends on brs_pkg for the register index width.
interface brs_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] low_bound;
  logic signed [31:0] high_bound;
  logic signed [31:0] low_value;
  logic signed [31:0] high_value;
  logic signed [31:0] function_value;

  modport source (output valid, output mode, output low_bound, output high_bound,
                  output low_value, output high_value, output function_value,
                  input ready);
  modport sink (input valid, input mode, input low_bound, input high_bound,
                input low_value, input high_value, input function_value,
                output ready);
endinterface

interface brs_out_if;
  logic               valid;
  logic               ready;
  logic               finished;
  logic signed [31:0] point;
  logic               root_valid;
  logic [2:0]         status_code;
  logic [15:0]        iterations_done;

  modport source (output valid, output finished, output point, output root_valid,
                  output status_code, output iterations_done, input ready);
  modport sink (input valid, input finished, input point, input root_valid,
                input status_code, input iterations_done, output ready);
endinterface

interface brs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [brs_pkg::CfgIndexWidth-1:0]   index;
  logic [31:0]                         data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/brs_cfg.sv
// Configuration registers of the bisection root search block.
// Takes write beats from the configuration channel; depends on brs_pkg
// and brs_cfg_if.
module brs_cfg (
  input  logic          clk,
  input  logic          rst_n,
  brs_cfg_if.sink       cfg_chan,
  output brs_pkg::cfg_t cfg
);

  brs_pkg::cfg_t cfg_r;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tolerance       <= brs_pkg::TOLERANCE_RESET;
      cfg_r.iteration_limit <= brs_pkg::ITERATION_LIMIT_RESET;
      cfg_r.near_zero_limit <= brs_pkg::NEAR_ZERO_LIMIT_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        brs_pkg::CFG_TOLERANCE:       cfg_r.tolerance       <= cfg_chan.data[30:0];
        brs_pkg::CFG_ITERATION_LIMIT: cfg_r.iteration_limit <= cfg_chan.data[15:0];
        brs_pkg::CFG_NEAR_ZERO_LIMIT: cfg_r.near_zero_limit <= cfg_chan.data[30:0];
        default: ;
      endcase
    end
  end

endmodule

### src/brs_step.sv
// Next-state and result logic of the bisection root search block.
// Combinational: one item, the search state and the registers in, the new
// state and the result item out. Depends on brs_pkg.
module brs_step (
  input  brs_pkg::item_t   item,
  input  brs_pkg::state_t  state,
  input  brs_pkg::cfg_t    cfg,
  output brs_pkg::state_t  state_nxt,
  output brs_pkg::result_t result
);

  logic               is_start;
  logic               bad_range;
  logic [31:0]        f_mag;
  logic               near_zero;
  logic               side_right;
  logic signed [31:0] l_use;
  logic signed [31:0] r_use;
  logic               neg_use;
  logic [15:0]        cnt_use;
  logic [15:0]        cnt_inc;
  logic signed [33:0] diff;
  logic signed [33:0] tol2;
  logic signed [32:0] sum;
  logic signed [31:0] mid;
  logic               wide;
  logic               room;

  always_comb begin
    is_start   = (item.mode == brs_pkg::MODE_START);
    bad_range  = (item.low_value == 32'sd0) || (item.high_value == 32'sd0) ||
                 (item.low_value[31] == item.high_value[31]);
    f_mag      = item.function_value[31] ? (~item.function_value + 32'd1)
                                         : item.function_value;
    near_zero  = (item.function_value == 32'sd0) || (f_mag < {1'b0, cfg.near_zero_limit});
    side_right = (item.function_value[31] != state.left_sign_negative);

    if (is_start) begin
      l_use   = item.low_bound;
      r_use   = item.high_bound;
      neg_use = item.low_value[31];
      cnt_use = 16'd0;
    end else begin
      l_use   = side_right ? state.left_end : state.pending_midpoint;
      r_use   = side_right ? state.pending_midpoint : state.right_end;
      neg_use = side_right ? state.left_sign_negative : item.function_value[31];
      cnt_use = state.iteration_count;
    end

    diff    = {{2{r_use[31]}}, r_use} - {{2{l_use[31]}}, l_use};
    tol2    = {2'b00, cfg.tolerance, 1'b0};
    wide    = diff > tol2;
    sum     = {l_use[31], l_use} + {r_use[31], r_use};
    mid     = sum[32:1];
    room    = cnt_use < cfg.iteration_limit;
    cnt_inc = cnt_use + 16'd1;

    state_nxt = state;
    result.finished        = 1'b1;
    result.point           = 32'sd0;
    result.root_valid      = 1'b0;
    result.status_code     = brs_pkg::STATUS_OK;
    result.iterations_done = state.iteration_count;

    priority if (is_start && bad_range) begin
      state_nxt.searching       = 1'b0;
      state_nxt.iteration_count = 16'd0;
      result.status_code        = brs_pkg::STATUS_BAD_RANGE;
      result.iterations_done    = 16'd0;
    end else if (!is_start && !state.searching) begin
      result.status_code = brs_pkg::STATUS_UNEXPECTED;
    end else if (!is_start && near_zero) begin
      state_nxt.searching = 1'b0;
      result.point        = state.pending_midpoint;
      result.root_valid   = 1'b1;
      result.status_code  = brs_pkg::STATUS_NEAR_ZERO;
    end else begin
      state_nxt.left_end           = l_use;
      state_nxt.right_end          = r_use;
      state_nxt.left_sign_negative = neg_use;
      if (wide && room) begin
        state_nxt.searching        = 1'b1;
        state_nxt.pending_midpoint = mid;
        state_nxt.iteration_count  = cnt_inc;
        result.finished            = 1'b0;
        result.point               = mid;
        result.iterations_done     = cnt_inc;
      end else begin
        state_nxt.searching       = 1'b0;
        state_nxt.iteration_count = cnt_use;
        result.iterations_done    = cnt_use;
        if (!room) begin
          result.status_code = brs_pkg::STATUS_LIMIT_HIT;
        end else begin
          result.point      = mid;
          result.root_valid = 1'b1;
        end
      end
    end
  end

endmodule

### src/bisection_root_search.sv
// Top level of the bisection root search block.
// Input register, step logic, search state and result register.
// Depends on brs_pkg, the channel interfaces, brs_cfg and brs_step.

// Every input beat gives exactly one result beat, by way of the input register
// and the result register. A new item is accepted every cycle while the result
// side is ready, since one pass through the step logic from the input register
// to the result register decides the result and updates the search state. A
// start beat answers with the first midpoint query or with a final result, and
// each reply beat answers with the next query or with the final result, so the
// evaluator's round trip sets the pace of a search. Configuration beats are
// taken every cycle and must only be sent while the block is idle.
module bisection_root_search (
  input logic      clk,
  input logic      rst_n,
  brs_in_if.sink   in_chan,
  brs_out_if.source out_chan,
  brs_cfg_if.sink  cfg_chan
);

  brs_pkg::cfg_t    cfg;
  brs_pkg::item_t   inq_r;
  logic             inq_valid_r;
  brs_pkg::state_t  state_r;
  brs_pkg::state_t  state_nxt;
  brs_pkg::result_t result_nxt;
  brs_pkg::result_t out_r;
  logic             out_valid_r;
  logic             move;

  brs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  brs_step u_step (
    .item      (inq_r),
    .state     (state_r),
    .cfg       (cfg),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  assign move          = inq_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !inq_valid_r || move;

  assign out_chan.valid           = out_valid_r;
  assign out_chan.finished        = out_r.finished;
  assign out_chan.point           = out_r.point;
  assign out_chan.root_valid      = out_r.root_valid;
  assign out_chan.status_code     = out_r.status_code;
  assign out_chan.iterations_done = out_r.iterations_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_chan.ready) begin
        inq_valid_r <= in_chan.valid;
      end
      if (move) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      inq_r.mode           <= in_chan.mode;
      inq_r.low_bound      <= in_chan.low_bound;
      inq_r.high_bound     <= in_chan.high_bound;
      inq_r.low_value      <= in_chan.low_value;
      inq_r.high_value     <= in_chan.high_value;
      inq_r.function_value <= in_chan.function_value;
    end
    if (move) begin
      out_r <= result_nxt;
    end
  end

endmodule

### src/brs_chk.sv
// Port checker for the bisection root search block, bound to the top level.
// Watches the result channel and reset; depends on brs_pkg.
module brs_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_finished,
  input logic signed [31:0] out_point,
  input logic               out_root_valid,
  input logic [2:0]         out_status_code,
  input logic [15:0]        out_iterations_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point) &&
      $stable(out_finished) && $stable(out_status_code) &&
      $stable(out_iterations_done))
    else $error("Stalled result beat changed.");

  a_query_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> !out_root_valid &&
      out_status_code == brs_pkg::STATUS_OK && out_iterations_done != 16'd0)
    else $error("Query beat carries a final result field.");

  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_code == brs_pkg::STATUS_BAD_RANGE |->
      out_finished && !out_root_valid && out_point == 32'sd0 &&
      out_iterations_done == 16'd0)
    else $error("Rejected interval beat is malformed.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result beat offered right after reset.");

endmodule

bind bisection_root_search brs_chk u_brs_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_finished        (out_chan.finished),
  .out_point           (out_chan.point),
  .out_root_valid      (out_chan.root_valid),
  .out_status_code     (out_chan.status_code),
  .out_iterations_done (out_chan.iterations_done)
);

### test/tb.sv
// Self-checking testbench for the bisection root search block, with its own
// search predictor, a directed table of beats and random well-formed searches.
// Depends on brs_pkg, the channel interfaces and bisection_root_search.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    brs_pkg::item_t   beat;
    bit               typed;
    brs_pkg::result_t want;
    logic [30:0]      tol;
    logic [15:0]      lim;
    logic [30:0]      nz;
  } row_t;

  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  bit   clk = 0;
  logic rst_n = 0;

  brs_in_if  in_chan();
  brs_out_if out_chan();
  brs_cfg_if cfg_chan();

  bisection_root_search i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  logic [30:0] tol_reg = brs_pkg::TOLERANCE_RESET;
  logic [15:0] lim_reg = brs_pkg::ITERATION_LIMIT_RESET;
  logic [30:0] nz_reg  = brs_pkg::NEAR_ZERO_LIMIT_RESET;

  longint      left_end = 0;
  longint      right_end = 0;
  bit          left_neg = 0;
  longint      probe_point = 0;
  logic [15:0] probes_done = '0;
  bit          search_active = 0;

  brs_pkg::result_t answers_due[$];
  row_t             rows[$];
  int               fail_count = 0;
  int               beats_sent = 0;
  bit               in_high = 0;
  bit               no_stalls = 0;

  function automatic brs_pkg::result_t mk_result(logic fin, logic signed [31:0] pt,
                                                 logic rv, logic [2:0] code,
                                                 logic [15:0] its);
    brs_pkg::result_t r;
    r.finished = fin;
    r.point = pt;
    r.root_valid = rv;
    r.status_code = code;
    r.iterations_done = its;
    return r;
  endfunction

  function automatic brs_pkg::result_t next_probe();
    longint span;
    longint mid;
    bit     wide;
    bit     room;
    span = right_end - left_end;
    wide = span > 2 * longint'(tol_reg);
    room = probes_done < lim_reg;
    mid = (left_end + right_end) >>> 1;
    if (wide && room) begin
      probe_point = mid;
      probes_done = probes_done + 16'd1;
      return mk_result(1'b0, mid[31:0], 1'b0, brs_pkg::STATUS_OK, probes_done);
    end
    search_active = 0;
    if (!room) begin
      return mk_result(1'b1, '0, 1'b0, brs_pkg::STATUS_LIMIT_HIT, probes_done);
    end
    return mk_result(1'b1, mid[31:0], 1'b1, brs_pkg::STATUS_OK, probes_done);
  endfunction

  function automatic brs_pkg::result_t bisect_step(brs_pkg::item_t it);
    longint fa;
    longint fb;
    longint f;
    longint mag;
    if (it.mode == brs_pkg::MODE_START) begin
      fa = longint'(it.low_value);
      fb = longint'(it.high_value);
      probes_done = '0;
      if (fa == 0 || fb == 0 || ((fa < 0) == (fb < 0))) begin
        search_active = 0;
        return mk_result(1'b1, '0, 1'b0, brs_pkg::STATUS_BAD_RANGE, probes_done);
      end
      left_end = longint'(it.low_bound);
      right_end = longint'(it.high_bound);
      left_neg = fa < 0;
      search_active = 1;
      return next_probe();
    end
    if (!search_active) begin
      return mk_result(1'b1, '0, 1'b0, brs_pkg::STATUS_UNEXPECTED, probes_done);
    end
    f = longint'(it.function_value);
    mag = f < 0 ? -f : f;
    if (f == 0 || mag < longint'(nz_reg)) begin
      search_active = 0;
      return mk_result(1'b1, probe_point[31:0], 1'b1, brs_pkg::STATUS_NEAR_ZERO,
                       probes_done);
    end
    if ((f < 0) != left_neg) begin
      right_end = probe_point;
    end else begin
      left_end = probe_point;
      left_neg = f < 0;
    end
    return next_probe();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    brs_pkg::result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing due, point %0d",
                                  out_chan.point));
      end else begin
        want = answers_due.pop_front();
        if (out_chan.finished !== want.finished)
          report_mismatch($sformatf("finished got %0d want %0d",
                                    out_chan.finished, want.finished));
        if (out_chan.point !== want.point)
          report_mismatch($sformatf("point got %0d want %0d", out_chan.point, want.point));
        if (out_chan.root_valid !== want.root_valid)
          report_mismatch($sformatf("root_valid got %0d want %0d",
                                    out_chan.root_valid, want.root_valid));
        if (out_chan.status_code !== want.status_code)
          report_mismatch($sformatf("status_code got %0d want %0d",
                                    out_chan.status_code, want.status_code));
        if (out_chan.iterations_done !== want.iterations_done)
          report_mismatch($sformatf("iterations_done got %0d want %0d",
                                    out_chan.iterations_done, want.iterations_done));
      end
    end
    out_chan.ready <= no_stalls || ($urandom_range(99) >= 7);
  end

  task automatic push_beat(input brs_pkg::item_t it, input bit typed,
                           input brs_pkg::result_t want);
    brs_pkg::result_t got;
    while (!no_stalls && $urandom_range(99) < 7) begin
      if (in_high) begin
        in_chan.valid <= 1'b0;
        in_high = 0;
      end
      @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.mode           <= it.mode;
    in_chan.low_bound      <= it.low_bound;
    in_chan.high_bound     <= it.high_bound;
    in_chan.low_value      <= it.low_value;
    in_chan.high_value     <= it.high_value;
    in_chan.function_value <= it.function_value;
    in_high = 1;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    got = bisect_step(it);
    answers_due.push_back(typed ? want : got);
    beats_sent++;
  endtask

  task automatic drain_results();
    if (in_high) begin
      in_chan.valid <= 1'b0;
      in_high = 0;
    end
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  task automatic write_reg(input logic [brs_pkg::CfgIndexWidth-1:0] idx,
                           input logic [31:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!(cfg_chan.valid && cfg_chan.ready));
    case (idx)
      brs_pkg::CFG_TOLERANCE:       tol_reg = data[30:0];
      brs_pkg::CFG_ITERATION_LIMIT: lim_reg = data[15:0];
      brs_pkg::CFG_NEAR_ZERO_LIMIT: nz_reg  = data[30:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [30:0] t, input logic [15:0] l,
                              input logic [30:0] n);
    logic [31:0] noise;
    drain_results();
    noise = $urandom;
    write_reg(brs_pkg::CFG_TOLERANCE, {noise[31], t});
    write_reg(brs_pkg::CFG_ITERATION_LIMIT, {noise[30:15], l});
    write_reg(brs_pkg::CFG_NEAR_ZERO_LIMIT, {noise[14], n});
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_value(bit neg, bit nonzero);
    longint mag;
    case ($urandom_range(9))
      0: mag = neg ? 64'sd2147483648 : 64'sd2147483647;
      1, 2: mag = $urandom_range(1 << 17, 0);
      3: mag = longint'(nz_reg) + $urandom_range(2, 0) - 1;
      default: mag = $urandom_range(32'h7FFF_FFFF, 0);
    endcase
    if (mag < 0) mag = 0;
    if (mag > 64'sd2147483648) mag = 64'sd2147483648;
    if (!neg && mag > 64'sd2147483647) mag = 64'sd2147483647;
    if (nonzero && mag == 0) mag = 1;
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  task automatic run_search(input bit reversed);
    brs_pkg::item_t it;
    longint         a;
    longint         b;
    longint         t;
    int             budget;
    bit             neg;
    case ($urandom_range(2))
      0: begin
        a = longint'(int'($urandom));
        b = longint'(int'($urandom));
      end
      1: begin
        a = longint'(int'($urandom));
        b = a + longint'($urandom_range(1 << 20, 0));
        if (b > 64'sd2147483647) b = 64'sd2147483647;
      end
      default: begin
        a = -longint'($urandom_range(1 << 18, 0));
        b = longint'($urandom_range(1 << 18, 0));
      end
    endcase
    if ((a > b) != reversed) begin
      t = a;
      a = b;
      b = t;
    end
    neg = $urandom_range(1);
    it.mode = brs_pkg::MODE_START;
    it.low_bound = a[31:0];
    it.high_bound = b[31:0];
    it.low_value = pick_value(neg, 1'b1);
    it.high_value = pick_value(!neg, 1'b1);
    it.function_value = $urandom;
    push_beat(it, 1'b0, '0);
    budget = $urandom_range(48, 1);
    while (search_active && budget > 0) begin
      it.mode = brs_pkg::MODE_REPLY;
      it.low_bound = $urandom;
      it.high_bound = $urandom;
      it.low_value = $urandom;
      it.high_value = $urandom;
      it.function_value = pick_value($urandom_range(1), 1'b0);
      push_beat(it, 1'b0, '0);
      budget--;
    end
  endtask

  task automatic push_noise();
    brs_pkg::item_t it;
    if ($urandom_range(1)) begin
      run_search(1'b1);
    end else begin
      it.mode = $urandom_range(1) ? brs_pkg::MODE_REPLY : brs_pkg::MODE_START;
      it.low_bound = $urandom;
      it.high_bound = $urandom;
      it.low_value = $urandom;
      it.high_value = $urandom;
      it.function_value = $urandom;
      push_beat(it, 1'b0, '0);
    end
  endtask

  function automatic void add_beat(logic mode, logic [31:0] lb, logic [31:0] hb,
                                   logic [31:0] lv, logic [31:0] hv, logic [31:0] fv);
    row_t r;
    r.kind = ROW_BEAT;
    r.beat.mode = mode;
    r.beat.low_bound = lb;
    r.beat.high_bound = hb;
    r.beat.low_value = lv;
    r.beat.high_value = hv;
    r.beat.function_value = fv;
    r.typed = 0;
    r.want = '0;
    r.tol = '0;
    r.lim = '0;
    r.nz = '0;
    rows.push_back(r);
  endfunction

  function automatic void add_want(logic fin, logic signed [31:0] pt, logic rv,
                                   logic [2:0] code, logic [15:0] its);
    rows[rows.size()-1].typed = 1;
    rows[rows.size()-1].want = mk_result(fin, pt, rv, code, its);
  endfunction

  function automatic void add_cfg(logic [30:0] t, logic [15:0] l, logic [30:0] n);
    row_t r;
    r.kind = ROW_CFG;
    r.beat = '0;
    r.typed = 0;
    r.want = '0;
    r.tol = t;
    r.lim = l;
    r.nz = n;
    rows.push_back(r);
  endfunction

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int target;
    in_chan.valid = 1'b0;
    in_chan.mode = brs_pkg::MODE_START;
    in_chan.low_bound = '0;
    in_chan.high_bound = '0;
    in_chan.low_value = '0;
    in_chan.high_value = '0;
    in_chan.function_value = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = brs_pkg::CFG_TOLERANCE;
    cfg_chan.data = '0;
    target = 0;

    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, QMAX);
    add_want(1, 0, 0, brs_pkg::STATUS_UNEXPECTED, 0);
    add_beat(brs_pkg::MODE_START, QMIN, QMAX, 0, 5, 0);
    add_want(1, 0, 0, brs_pkg::STATUS_BAD_RANGE, 0);
    add_beat(brs_pkg::MODE_START, QMIN, QMAX, 5, 0, 0);
    add_want(1, 0, 0, brs_pkg::STATUS_BAD_RANGE, 0);
    add_beat(brs_pkg::MODE_START, 0, ONE, 1, QMAX, 0);
    add_want(1, 0, 0, brs_pkg::STATUS_BAD_RANGE, 0);
    add_beat(brs_pkg::MODE_START, 0, ONE, QMIN, -1, 0);
    add_want(1, 0, 0, brs_pkg::STATUS_BAD_RANGE, 0);
    add_beat(brs_pkg::MODE_START, QMIN, QMAX, -1, QMAX, 0);
    add_want(0, -1, 0, brs_pkg::STATUS_OK, 1);
    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, 0);
    add_want(1, -1, 1, brs_pkg::STATUS_NEAR_ZERO, 1);
    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, 3);
    add_want(1, 0, 0, brs_pkg::STATUS_UNEXPECTED, 1);
    add_beat(brs_pkg::MODE_START, 100 * ONE, -100 * ONE, -1, 1, 0);
    add_want(1, 0, 1, brs_pkg::STATUS_OK, 0);
    add_beat(brs_pkg::MODE_START, 0, 14, -1, 1, 0);
    add_want(1, 7, 1, brs_pkg::STATUS_OK, 0);
    add_beat(brs_pkg::MODE_START, 0, 16 * ONE, 1, QMIN, 0);
    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, QMIN);
    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, QMAX);
    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, 1);
    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, -1);
    add_beat(brs_pkg::MODE_START, -ONE, ONE, QMAX, QMIN, 0);
    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, -7);
    add_cfg(0, 1, 0);
    add_beat(brs_pkg::MODE_START, 0, ONE, -1, 1, 0);
    add_want(0, 32'sh8000, 0, brs_pkg::STATUS_OK, 1);
    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, 0);
    add_want(1, 32'sh8000, 1, brs_pkg::STATUS_NEAR_ZERO, 1);
    add_cfg(0, 0, 0);
    add_beat(brs_pkg::MODE_START, 0, ONE, -1, 1, 0);
    add_want(1, 0, 0, brs_pkg::STATUS_LIMIT_HIT, 0);
    add_beat(brs_pkg::MODE_START, 5, 5, 1, -1, 0);
    add_want(1, 0, 0, brs_pkg::STATUS_LIMIT_HIT, 0);
    add_cfg(31'h7FFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF);
    add_beat(brs_pkg::MODE_START, QMIN, QMAX, 1, -1, 0);
    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, QMAX);
    add_beat(brs_pkg::MODE_START, QMIN, QMAX, -1, 1, 0);
    add_beat(brs_pkg::MODE_REPLY, 0, 0, 0, 0, QMIN);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) begin
        program_regs(rows[k].tol, rows[k].lim, rows[k].nz);
      end else begin
        push_beat(rows[k].beat, rows[k].typed, rows[k].want);
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_regs(brs_pkg::TOLERANCE_RESET, brs_pkg::ITERATION_LIMIT_RESET,
                        brs_pkg::NEAR_ZERO_LIMIT_RESET);
        1: program_regs(31'd0, 16'hFFFF, 31'd0);
        2: program_regs(31'h7FFF_FFFF, 16'd1, 31'h7FFF_FFFF);
        3: program_regs($urandom_range(4095, 0), $urandom_range(40, 1),
                        $urandom_range(1 << 16, 0));
        4: program_regs($urandom, $urandom_range(65535, 1), $urandom);
        default: program_regs($urandom_range(255, 0), $urandom_range(12, 2),
                              $urandom_range(1 << 20, 0));
      endcase
      no_stalls = (phase == 3);
      target += 140;
      while (beats_sent < target) begin
        if ($urandom_range(99) < 12) begin
          push_noise();
        end else begin
          run_search(1'b0);
        end
        if ($urandom_range(99) < 3) drain_results();
      end
    end

    no_stalls = 0;
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
